// File: rtl/pat_pkg.sv
// Package for the parent-pointer tree table.
// Holds command and status codes, sequencer states and shared record types.
// No dependencies.
`default_nettype none

package pat_pkg;

  // Default number of entries the table holds
  localparam int unsigned CapacityDefault = 32;

  // Fixed field widths
  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValW   = 8;
  localparam int unsigned LeafW  = 7;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned StatW  = 3;

  typedef enum logic [CmdW-1:0] {
    CmdInsert   = 2'd0,
    CmdParent   = 2'd1,
    CmdChildren = 2'd2,
    CmdLeaves   = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StatOk       = 3'd0,
    StatDup      = 3'd1,
    StatNoParent = 3'd2,
    StatNoKey    = 3'd3,
    StatNoChild  = 3'd4,
    StatFull     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SqIdle   = 2'd0,
    SqScan   = 2'd1,
    SqFinish = 2'd2
  } seq_state_e;

  // One stored table entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [KeyW-1:0] parent;
  } entry_t;

  // Compare unit outcome for one entry
  typedef struct packed {
    logic key_hit;    // entry key equals item key
    logic pkey_hit;   // entry key equals item parent key
    logic child_hit;  // non-root entry whose parent equals item parent key
  } match_t;

  // One result transaction
  typedef struct packed {
    status_e          status;
    logic [KeyW-1:0]  out_key;
    logic [ValW-1:0]  out_value;
    logic [KeyW-1:0]  out_parent;
    logic             is_root;
    logic [LeafW-1:0] leaf_count;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pat_store.sv
// Entry memory of the tree table: one write port, one registered read port.
// Depends on pat_pkg.
`default_nettype none

module pat_store
  import pat_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rd_en_i,
  input  wire logic [$clog2(Capacity)-1:0] rd_addr_i,
  output      entry_t                      rd_entry_o,
  input  wire logic                        wr_en_i,
  input  wire logic [$clog2(Capacity)-1:0] wr_addr_i,
  input  wire entry_t                      wr_entry_i
);

  entry_t mem_q [Capacity];
  entry_t rd_q;

  // Write port; contents undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

`default_nettype wire

// File: rtl/pat_match.sv
// Shared compare unit: checks one scanned entry against the current transaction.
// Depends on pat_pkg.
`default_nettype none

module pat_match
  import pat_pkg::*;
(
  input  wire entry_t          entry_i,
  input  wire logic            is_first_i,  // entry is the root slot
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic [KeyW-1:0] pkey_i,
  output      match_t          match_o
);

  always_comb begin
    match_o.key_hit   = (entry_i.key == key_i);
    match_o.pkey_hit  = (entry_i.key == pkey_i);
    // root parent slot is never compared
    match_o.child_hit = !is_first_i && (entry_i.parent == pkey_i);
  end

endmodule

`default_nettype wire

// File: rtl/pat_ctrl.sv
// Sequencer of the tree table: scans stored entries one per cycle through the
// compare unit and issues results. Depends on pat_pkg, pat_match.
`default_nettype none

module pat_ctrl
  import pat_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [CmdW-1:0]             cmd_i,
  input  wire logic [KeyW-1:0]             key_i,
  input  wire logic [ValW-1:0]             value_i,
  input  wire logic [KeyW-1:0]             parent_key_i,
  output      logic                        rd_en_o,
  output      logic [$clog2(Capacity)-1:0] rd_addr_o,
  input  wire entry_t                      rd_entry_i,
  output      logic                        wr_en_o,
  output      logic [$clog2(Capacity)-1:0] wr_addr_o,
  output      entry_t                      wr_entry_o,
  output      logic                        res_valid_o,
  output      result_t                     res_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  seq_state_e state_q, state_d;

  // Latched transaction
  cmd_e            cmd_q, cmd_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic [KeyW-1:0] pkey_q, pkey_d;

  // Scan pointers: issue side and compare side
  logic [CntW-1:0]  idx_q, idx_d;
  logic             rvalid_q, rvalid_d;
  logic [AddrW-1:0] ridx_q, ridx_d;

  // Scan findings
  logic             hit_q, hit_d;
  logic             pfound_q, pfound_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  logic             qroot_q, qroot_d;
  logic [KeyW-1:0]  qpar_q, qpar_d;

  // Child waiting for its last flag
  logic            pend_q, pend_d;
  logic [KeyW-1:0] pend_key_q, pend_key_d;
  logic [ValW-1:0] pend_val_q, pend_val_d;

  // Table bookkeeping
  logic [CntW-1:0]     n_q, n_d;
  logic [CntW-1:0]     leaves_q, leaves_d;
  logic [Capacity-1:0] has_child_q, has_child_d;

  // Result register
  logic    valid_q, valid_d;
  result_t res_q, res_d;

  match_t match;

  pat_match u_match (
    .entry_i    (rd_entry_i),
    .is_first_i (ridx_q == '0),
    .key_i      (key_q),
    .pkey_i     (pkey_q),
    .match_o    (match)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SqIdle;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      leaves_q    <= '0;
      has_child_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rvalid_q    <= rvalid_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      leaves_q    <= leaves_d;
      has_child_q <= has_child_d;
      valid_q     <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    pkey_q     <= pkey_d;
    ridx_q     <= ridx_d;
    hit_q      <= hit_d;
    pfound_q   <= pfound_d;
    pidx_q     <= pidx_d;
    qroot_q    <= qroot_d;
    qpar_q     <= qpar_d;
    pend_key_q <= pend_key_d;
    pend_val_q <= pend_val_d;
    res_q      <= res_d;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    pkey_d      = pkey_q;
    idx_d       = idx_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    hit_d       = hit_q;
    pfound_d    = pfound_q;
    pidx_d      = pidx_q;
    qroot_d     = qroot_q;
    qpar_d      = qpar_q;
    pend_d      = pend_q;
    pend_key_d  = pend_key_q;
    pend_val_d  = pend_val_q;
    n_d         = n_q;
    leaves_d    = leaves_q;
    has_child_d = has_child_q;
    valid_d     = 1'b0;
    res_d       = res_q;

    rd_en_o           = 1'b0;
    rd_addr_o         = idx_q[AddrW-1:0];
    wr_en_o           = 1'b0;
    wr_addr_o         = n_q[AddrW-1:0];
    wr_entry_o.key    = key_q;
    wr_entry_o.value  = val_q;
    wr_entry_o.parent = (n_q == '0) ? '0 : pkey_q;

    unique case (state_q)
      SqIdle: begin
        if (start) begin
          cmd_d    = cmd_e'(cmd_i);
          key_d    = key_i;
          val_d    = value_i;
          pkey_d   = parent_key_i;
          idx_d    = '0;
          hit_d    = 1'b0;
          pfound_d = 1'b0;
          qroot_d  = 1'b0;
          qpar_d   = '0;
          pend_d   = 1'b0;
          state_d  = SqScan;
        end
      end

      SqScan: begin
        // issue next read
        if (idx_q < n_q) begin
          rd_en_o  = 1'b1;
          rvalid_d = 1'b1;
          ridx_d   = idx_q[AddrW-1:0];
          idx_d    = CntW'(idx_q + 1'b1);
        end
        // compare the entry read last cycle
        if (rvalid_q) begin
          case (cmd_q)
            CmdInsert: begin
              if (match.key_hit) hit_d = 1'b1;
              if (match.pkey_hit) begin
                pfound_d = 1'b1;
                pidx_d   = ridx_q;
              end
            end
            CmdParent: begin
              if (match.key_hit) begin
                hit_d   = 1'b1;
                qroot_d = (ridx_q == '0);
                qpar_d  = (ridx_q == '0) ? '0 : rd_entry_i.parent;
              end
            end
            CmdChildren: begin
              if (match.child_hit) begin
                // a newer child means the pending one is not last
                if (pend_q) begin
                  valid_d         = 1'b1;
                  res_d           = '0;
                  res_d.status    = StatOk;
                  res_d.out_key   = pend_key_q;
                  res_d.out_value = pend_val_q;
                end
                pend_d     = 1'b1;
                pend_key_d = rd_entry_i.key;
                pend_val_d = rd_entry_i.value;
              end
            end
            default: ;
          endcase
        end
        if ((idx_q == n_q) && !rvalid_q) begin
          state_d = SqFinish;
        end
      end

      SqFinish: begin
        valid_d      = 1'b1;
        res_d        = '0;
        res_d.last   = 1'b1;
        res_d.status = StatOk;
        case (cmd_q)
          CmdInsert: begin
            if (hit_q) begin
              res_d.status = StatDup;
            end else if (n_q >= CntW'(Capacity)) begin
              res_d.status = StatFull;
            end else if ((n_q != '0) && !pfound_q) begin
              res_d.status = StatNoParent;
            end else begin
              // append entry and keep the leaf count current
              wr_en_o                         = 1'b1;
              n_d                             = CntW'(n_q + 1'b1);
              has_child_d[n_q[AddrW-1:0]]     = 1'b0;
              if (n_q == '0) begin
                leaves_d = CntW'(1);
              end else begin
                has_child_d[pidx_q] = 1'b1;
                if (has_child_q[pidx_q]) leaves_d = CntW'(leaves_q + 1'b1);
              end
            end
          end
          CmdParent: begin
            if (!hit_q) begin
              res_d.status = StatNoKey;
            end else begin
              res_d.is_root    = qroot_q;
              res_d.out_parent = qpar_q;
            end
          end
          CmdChildren: begin
            if (pend_q) begin
              res_d.out_key   = pend_key_q;
              res_d.out_value = pend_val_q;
            end else begin
              res_d.status = StatNoChild;
            end
          end
          default: begin
            res_d.leaf_count = LeafW'(leaves_q);
          end
        endcase
        state_d = SqIdle;
      end

      default: state_d = SqIdle;
    endcase
  end

  assign busy        = (state_q != SqIdle);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: rtl/parent_array_tree_table.sv
// Parent-pointer tree table. Each transaction scans all n stored entries, n being the
// number of stored entries, with one memory read and one compare per cycle, and then issues
// its final result. A new transaction is taken only once the previous one has finished,
// while busy is low. Children arrive as one strobe each.
// Reset (asynchronous, active low) empties the table; memory contents are
// left as they are. Results are strobed once and cannot be stalled.
`default_nettype none

module parent_array_tree_table
  import pat_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [CmdW-1:0]   cmd_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [ValW-1:0]   value_i,
  input  wire logic [KeyW-1:0]   parent_key_i,
  output      logic              valid_o,
  output      logic [StatW-1:0]  status_o,
  output      logic [KeyW-1:0]   out_key_o,
  output      logic [ValW-1:0]   out_value_o,
  output      logic [KeyW-1:0]   out_parent_o,
  output      logic              is_root_o,
  output      logic [LeafW-1:0]  leaf_count_o,
  output      logic              last_o
);

  localparam int unsigned AddrW = $clog2(Capacity);

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  entry_t           rd_entry;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_entry;
  result_t          res;

  pat_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .parent_key_i (parent_key_i),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_entry_i   (rd_entry),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_entry_o   (wr_entry),
    .res_valid_o  (valid_o),
    .res_o        (res)
  );

  pat_store #(
    .Capacity (Capacity)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  // Result fields onto ports
  assign status_o     = res.status;
  assign out_key_o    = res.out_key;
  assign out_value_o  = res.out_value;
  assign out_parent_o = res.out_parent;
  assign is_root_o    = res.is_root;
  assign leaf_count_o = res.leaf_count;
  assign last_o       = res.last;

endmodule

`default_nettype wire

// File: rtl/pat_checker.sv
// Port-level checks for the tree table, bound to the top level.
// Depends on pat_pkg.
`default_nettype none

module pat_checker
  import pat_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             valid_o,
  input wire logic [StatW-1:0] status_o,
  input wire logic             last_o
);

  // An accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted start");

  // Results only come while a transaction is in flight or just after it
  a_valid_in_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy || $past(busy))
    else $error("result strobe outside a transaction");

  // Every error status is the sole, final result of its transaction
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != StatOk) |-> last_o)
    else $error("error status without last");

  // A non-final result leaves the transaction open
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy && (status_o == StatOk))
    else $error("non-final result while idle");

endmodule

bind parent_array_tree_table pat_checker u_pat_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .valid_o  (valid_o),
  .status_o (status_o),
  .last_o   (last_o)
);

`default_nettype wire
